// ===== hw/rtl/issm_pkg.sv =====
// Shared types, state and event codes for the iSCSI session state machine.
`timescale 1ns / 1ps

package issm_pkg;

  localparam int CNT_W         = 5;
  localparam int MAX_CONNS_DEF = 16;

  localparam logic [2:0] ST_FREE      = 3'd0;
  localparam logic [2:0] ST_ACTIVE    = 3'd1;
  localparam logic [2:0] ST_LOGGED_IN = 3'd2;
  localparam logic [2:0] ST_FAILED    = 3'd3;
  localparam logic [2:0] ST_CONTINUE  = 3'd4;
  localparam logic [2:0] ST_DONE      = 3'd5;
  localparam logic [2:0] ST_ERROR     = 3'd6;

  localparam logic [3:0] EV_IN_LOGIN    = 4'd0;
  localparam logic [3:0] EV_LOGGED_IN   = 4'd1;
  localparam logic [3:0] EV_CONN_FAIL   = 4'd2;
  localparam logic [3:0] EV_FFP_FAIL    = 4'd3;
  localparam logic [3:0] EV_FFP_DISABLE = 4'd4;
  localparam logic [3:0] EV_CLOSE       = 4'd5;
  localparam logic [3:0] EV_REINSTATE   = 4'd6;
  localparam logic [3:0] EV_TIMEOUT     = 4'd7;
  localparam logic [3:0] EV_ADMIN_CLOSE = 4'd8;

  localparam logic [1:0] LM_NONE       = 2'd0;
  localparam logic [1:0] LM_IMPLICIT   = 2'd1;
  localparam logic [1:0] LM_ALL_EXCEPT = 2'd2;
  localparam logic [1:0] LM_ASYNC      = 2'd3;

  typedef struct packed {
    logic [3:0]  event_req;
    logic [15:0] conn_id;
    logic [11:0] retain_seconds;
  } issm_in_t;

  typedef struct packed {
    logic [2:0]  state_out;
    logic [1:0]  logout_mode;
    logic [15:0] skip_conn;
    logic        bind_target;
    logic        end_session;
    logic        free_tsih;
    logic        start_timer;
    logic [11:0] timer_seconds;
    logic        cancel_timer;
    logic        wait_release;
    logic        unexpected_event;
  } issm_out_t;

  typedef struct packed {
    logic [2:0]       state;
    logic [2:0]       prev_state;
    logic [CNT_W-1:0] bound_conns;
    logic [CNT_W-1:0] ffp_conns;
    logic             admin_closing;
    logic [11:0]      saved_retain;
  } issm_sess_t;

  localparam issm_sess_t SESS_RESET = '{
    state:         ST_FREE,
    prev_state:    ST_FREE,
    bound_conns:   '0,
    ffp_conns:     '0,
    admin_closing: 1'b0,
    saved_retain:  '0
  };

endpackage

// ===== hw/rtl/iscsi_session_state_machine.sv =====
// Top level of the iSCSI target session state machine.
// Usage:
//   in_*  : one session event per beat (event code, connection id, retain time).
//   out_* : one result beat per event: new state plus action flags.
//   cfg_* : writes tsih_assigned; always ready, write only while idle.
// Path: the input register, then next-state logic into the result register
// together with the session state register.
// Throughput: one event per cycle while the output is not stalled; the session
// state register updates from combinational next-state logic, so back-to-back events are taken.
// Stall: when out_ready is low, the result register holds and one more
// event waits in the input register; in_ready drops only when both are full.
// Reset (rst_n low, synchronous): session state free, counts and flags
// cleared, saved retain zero, tsih_assigned set, both stages emptied.
`timescale 1ns / 1ps

module iscsi_session_state_machine #(
  parameter int MAX_CONNS = issm_pkg::MAX_CONNS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  issm_pkg::issm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output issm_pkg::issm_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import issm_pkg::*;

  localparam int               LIM_I     = (MAX_CONNS < 31) ? MAX_CONNS : 31;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LIM_I);

  logic       s1_valid_r;
  issm_in_t   s1_data_r;
  logic       out_valid_r;
  issm_out_t  out_r;
  issm_sess_t sess_r;
  issm_sess_t sess_nxt;
  issm_out_t  res;
  logic       tsih_r;
  logic       s1_move;
  logic       in_fire;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_move;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  issm_step #(
    .MAX_CONNS(MAX_CONNS)
  ) u_step (
    .sess         (sess_r),
    .tsih_assigned(tsih_r),
    .item         (s1_data_r),
    .sess_nxt     (sess_nxt),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sess_r      <= SESS_RESET;
      tsih_r      <= 1'b1;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
        sess_r      <= sess_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        tsih_r <= cfg_data;
      end
    end
  end

  // payload beats
  always_ff @(posedge clk) begin
    if (in_fire) s1_data_r <= in_data;
    if (s1_move) out_r <= res;
  end

  a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && sess_nxt.state != sess_r.state) |=> (sess_r.prev_state == $past(sess_r.state)))
    else $error("previous state not captured on transition");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (sess_r.bound_conns <= CNT_LIMIT) && (sess_r.ffp_conns <= CNT_LIMIT))
    else $error("connection count above limit");

  a_end_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.end_session) |->
      (out_r.state_out == ST_DONE || out_r.state_out == ST_ERROR))
    else $error("end_session outside done or error");

  a_timer_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.start_timer) |-> (out_r.state_out == ST_FAILED))
    else $error("start_timer outside failed");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with room available");

endmodule

// ===== hw/rtl/issm_step.sv =====
// Next-state and action logic for one session event.
`timescale 1ns / 1ps

module issm_step #(
  parameter int MAX_CONNS = issm_pkg::MAX_CONNS_DEF
) (
  input  issm_pkg::issm_sess_t sess,
  input  logic                 tsih_assigned,
  input  issm_pkg::issm_in_t   item,
  output issm_pkg::issm_sess_t sess_nxt,
  output issm_pkg::issm_out_t  res
);
  import issm_pkg::*;

  localparam int               LIM_I     = (MAX_CONNS < 31) ? MAX_CONNS : 31;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LIM_I);

  function automatic logic [CNT_W-1:0] cnt_up(input logic [CNT_W-1:0] c);
    return (c < CNT_LIMIT) ? c + 1'b1 : c;
  endfunction

  function automatic logic [CNT_W-1:0] cnt_dn(input logic [CNT_W-1:0] c);
    return (c == '0) ? c : c - 1'b1;
  endfunction

  logic [3:0] ev;
  logic       enter;
  logic [2:0] ns;

  assign ev = item.event_req;

  always_comb begin
    sess_nxt = sess;
    res      = '0;
    enter    = 1'b0;
    ns       = sess.state;
    if (ev > EV_ADMIN_CLOSE) begin
      res.unexpected_event = 1'b1;
    end else if (ev == EV_ADMIN_CLOSE) begin
      sess_nxt.admin_closing = 1'b1;
      if (sess.state == ST_LOGGED_IN) begin
        res.logout_mode = LM_ASYNC;
      end
    end else begin
      if (ev == EV_IN_LOGIN) begin
        sess_nxt.bound_conns = cnt_up(sess.bound_conns);
      end else if (ev == EV_CONN_FAIL) begin
        if (sess.bound_conns == '0) res.unexpected_event = 1'b1;
        sess_nxt.bound_conns = cnt_dn(sess.bound_conns);
      end
      case (sess.state)
        ST_FREE: begin
          if (ev == EV_IN_LOGIN) begin
            enter = 1'b1;
            ns    = ST_ACTIVE;
          end else begin
            res.unexpected_event = 1'b1;
          end
        end
        ST_ACTIVE: begin
          if (ev == EV_LOGGED_IN) begin
            sess_nxt.ffp_conns = cnt_up(sess.ffp_conns);
            enter = 1'b1;
            ns    = ST_LOGGED_IN;
          end else if (ev == EV_IN_LOGIN) begin
            ns = sess.state;
          end else if (ev == EV_CONN_FAIL) begin
            enter = 1'b1;
            ns    = ST_ERROR;
          end else if (ev == EV_REINSTATE) begin
            res.logout_mode = LM_IMPLICIT;
            enter = 1'b1;
            ns    = ST_DONE;
          end else begin
            res.unexpected_event = 1'b1;
          end
        end
        ST_LOGGED_IN: begin
          if (ev inside {EV_IN_LOGIN, EV_CONN_FAIL}) begin
            ns = sess.state;
          end else if (ev == EV_LOGGED_IN) begin
            sess_nxt.ffp_conns = cnt_up(sess.ffp_conns);
          end else if (ev inside {EV_FFP_FAIL, EV_FFP_DISABLE}) begin
            sess_nxt.saved_retain = item.retain_seconds;
            if (sess.ffp_conns == '0) res.unexpected_event = 1'b1;
            sess_nxt.ffp_conns = cnt_dn(sess.ffp_conns);
            if (sess_nxt.ffp_conns == '0) begin
              enter = 1'b1;
              ns    = (ev == EV_FFP_DISABLE || sess.admin_closing) ? ST_DONE : ST_FAILED;
            end
          end else if (ev == EV_CLOSE) begin
            if (sess.ffp_conns == '0) res.unexpected_event = 1'b1;
            sess_nxt.ffp_conns = cnt_dn(sess.ffp_conns);
            res.logout_mode = LM_ALL_EXCEPT;
            res.skip_conn   = item.conn_id;
            enter = 1'b1;
            ns    = ST_DONE;
          end else if (ev == EV_REINSTATE) begin
            res.logout_mode = LM_IMPLICIT;
            enter = 1'b1;
            ns    = ST_DONE;
          end else begin
            res.unexpected_event = 1'b1;
          end
        end
        ST_FAILED: begin
          if (ev == EV_IN_LOGIN) begin
            enter = 1'b1;
            ns    = ST_CONTINUE;
          end else if (ev == EV_REINSTATE) begin
            res.cancel_timer = 1'b1;
            enter = 1'b1;
            ns    = ST_DONE;
          end else if (ev == EV_TIMEOUT) begin
            enter = 1'b1;
            ns    = ST_DONE;
          end else if (ev == EV_CONN_FAIL) begin
            ns = sess.state;
          end else begin
            res.unexpected_event = 1'b1;
          end
        end
        ST_CONTINUE: begin
          if (ev == EV_CONN_FAIL) begin
            enter = 1'b1;
            ns    = ST_FAILED;
          end else if (ev == EV_LOGGED_IN) begin
            sess_nxt.ffp_conns = cnt_up(sess.ffp_conns);
            enter = 1'b1;
            ns    = ST_LOGGED_IN;
          end else if (ev == EV_REINSTATE) begin
            enter = 1'b1;
            ns    = ST_DONE;
          end else begin
            res.unexpected_event = 1'b1;
          end
        end
        ST_DONE: begin
          if (ev == EV_LOGGED_IN) begin
            sess_nxt.ffp_conns = cnt_up(sess.ffp_conns);
          end else if (ev inside {EV_FFP_FAIL, EV_FFP_DISABLE}) begin
            if (sess.ffp_conns == '0) res.unexpected_event = 1'b1;
            sess_nxt.ffp_conns = cnt_dn(sess.ffp_conns);
          end else if (ev == EV_CONN_FAIL && sess_nxt.bound_conns == '0) begin
            res.wait_release = 1'b1;
          end
        end
        ST_ERROR: begin
          if (ev == EV_CONN_FAIL && sess_nxt.bound_conns == '0) begin
            res.wait_release = 1'b1;
          end
        end
        default: begin
          res.unexpected_event = 1'b1;
        end
      endcase
    end

    if (enter) begin
      sess_nxt.prev_state = sess.state;
      sess_nxt.state      = ns;
      case (ns)
        ST_ACTIVE: res.bind_target = 1'b1;
        ST_FAILED: begin
          res.start_timer   = 1'b1;
          res.timer_seconds = sess_nxt.saved_retain;
        end
        ST_DONE, ST_ERROR: begin
          res.end_session = 1'b1;
          res.free_tsih   = tsih_assigned;
          if (sess_nxt.bound_conns == '0) res.wait_release = 1'b1;
        end
        default: res.bind_target = 1'b0;
      endcase
    end
    res.state_out = sess_nxt.state;
  end

endmodule
